@@ rtl/core/fcam_pkg.sv @@
package fcam_pkg;

  // Number of mixer channels in the item format; channels at or past this are silent.
  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned MaxChannels  = 4;

  localparam int unsigned SampleW      = 8;
  localparam int unsigned VolumeW      = 6;
  localparam int unsigned AttachW      = 8;
  localparam int unsigned InDataW      = MaxChannels * (SampleW + VolumeW) + AttachW;
  localparam int unsigned OutDataW     = 16;

  localparam int unsigned CfgIndexW    = 2;
  localparam int unsigned CfgDataW     = 18;
  localparam int unsigned CountW       = 17;

  localparam logic [CfgDataW-1:0] MaxBufferBytes   = 18'd131072;
  localparam logic [CfgDataW-1:0] BufferBytesReset = 18'd8192;
  localparam logic [1:0]          SoundLevelReset  = 2'd2;
  localparam logic [1:0]          SoundLevelMin    = 2'd2;
  localparam logic [15:0]         MulawClip        = 16'd8160;
  localparam logic [15:0]         MulawBias        = 16'd32;
  localparam logic [7:0]          MulawClipCode    = 8'h80;

  typedef enum logic [1:0] {
    ModeLinear16 = 2'd0,
    ModeOffset8  = 2'd1,
    ModeMulaw8   = 2'd2,
    ModeSigned8  = 2'd3
  } out_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegOutputMode  = 2'd0,
    RegSoundLevel  = 2'd1,
    RegBufferBytes = 2'd2,
    RegUnused      = 2'd3
  } cfg_reg_e;

  // Segmented mu-law encoder. Biasing the magnitude by 32 puts each segment
  // on a power-of-two boundary, so the segment is the leading one and the
  // mantissa is the next four bits below it, both inverted.
  function automatic logic [7:0] mulaw_encode(input logic signed [15:0] v);
    logic [15:0] mag;
    logic [15:0] biased;
    logic [15:0] shifted;
    logic [2:0]  seg;
    logic [7:0]  code;
    mag     = v[15] ? 16'(-v) : 16'(v);
    biased  = mag + MulawBias;
    seg     = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (biased[5 + k]) begin
        seg = 3'(k);
      end
    end
    shifted = biased >> ({1'b0, seg} + 4'd1);
    if (mag >= MulawClip) begin
      code = MulawClipCode;
    end else begin
      code = {1'b1, ~seg, ~shifted[3:0]};
    end
    if (v[15]) begin
      code[7] = 1'b0;
    end
    return code;
  endfunction

endpackage

@@ rtl/core/four_channel_audio_mixer.sv @@
// Path: an accepted item enters the input register, then its result the result
// register that drives the output, where it waits while the output is stalled.
// Throughput: one item per cycle unless the output stalls; the input and result
// registers let a new item in while a finished result still waits on the output.
// Reset: asynchronous, active low; clears the pipeline, the byte counter and
// loads the register defaults (16-bit linear, level 2, 8192-byte buffer).
module four_channel_audio_mixer #(
  parameter int unsigned Channels = fcam_pkg::CHANNELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fcam_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [fcam_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_ch0..3 [31:0], volume_ch0..3 [55:32], attach_bits [63:56]
  input  logic [fcam_pkg::InDataW-1:0]   s_axis_tdata,
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sample_word [15:0]
  output logic [fcam_pkg::OutDataW-1:0]  m_axis_tdata,
  // buffer_end
  output logic                           m_axis_tlast
);
  import fcam_pkg::*;

  localparam int unsigned MixChannels = (Channels < MaxChannels) ? Channels : MaxChannels;
  localparam int unsigned VolBase     = MaxChannels * SampleW;
  localparam int unsigned AttachBase  = MaxChannels * (SampleW + VolumeW);

  // Configuration registers
  out_mode_e            mode_q;
  logic [1:0]           level_q;
  logic [CfgDataW-1:0]  buf_bytes_q;

  // Input register
  logic                        in_valid_q;
  logic signed [SampleW-1:0]   samp_q [MaxChannels];
  logic        [VolumeW-1:0]   vol_q  [MaxChannels];
  logic        [AttachW-1:0]   attach_q;

  // Result register
  logic                  out_valid_q;
  logic [OutDataW-1:0]   word_q;
  logic                  last_q;

  logic [CountW-1:0]     count_q;
  logic [CountW-1:0]     count_d;

  logic                  advance;
  logic                  emit;
  logic signed [14:0]    prod      [MaxChannels];
  logic signed [6:0]     prod_div  [MaxChannels];
  logic signed [15:0]    sum_full;
  logic signed [7:0]     sum_small;
  logic [OutDataW-1:0]   word_d;
  logic [CfgDataW-1:0]   limit;
  logic [CfgDataW-1:0]   next_count;
  logic                  last_d;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign emit          = advance && in_valid_q && (level_q >= SoundLevelMin);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = word_q;
  assign m_axis_tlast  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeLinear16;
      level_q     <= SoundLevelReset;
      buf_bytes_q <= BufferBytesReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegOutputMode:  mode_q      <= out_mode_e'(cfg_data_i[1:0]);
        RegSoundLevel:  level_q     <= cfg_data_i[1:0];
        RegBufferBytes: buf_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Mixing: a channel drops out when its volume- or period-attach bit is set.
  always_comb begin
    sum_full  = '0;
    sum_small = '0;
    for (int ch = 0; ch < MaxChannels; ch++) begin
      prod[ch]     = samp_q[ch] * $signed({1'b0, vol_q[ch]});
      // Divide by 256 truncating toward zero: round the arithmetic shift up
      // for negative products with a non-zero remainder.
      prod_div[ch] = 7'(prod[ch] >>> 8) +
                     7'(prod[ch][14] && (prod[ch][7:0] != 8'd0));
      if ((ch < MixChannels) && !attach_q[ch] && !attach_q[ch + 4]) begin
        sum_full  = sum_full + 16'(prod[ch]);
        sum_small = sum_small + 8'(prod_div[ch]);
      end
    end
  end

  always_comb begin
    case (mode_q)
      ModeLinear16: word_d = sum_full;
      ModeOffset8:  word_d = {8'd0, sum_small + 8'd128};
      ModeMulaw8:   word_d = {8'd0, mulaw_encode(sum_full)};
      ModeSigned8:  word_d = {8'd0, sum_small};
      default:      word_d = '0;
    endcase
  end

  always_comb begin
    limit      = (buf_bytes_q > MaxBufferBytes) ? MaxBufferBytes : buf_bytes_q;
    next_count = {1'b0, count_q} + ((mode_q == ModeLinear16) ? 18'd2 : 18'd1);
    last_d     = (next_count >= limit);
    count_d    = last_d ? '0 : next_count[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      for (int ch = 0; ch < MaxChannels; ch++) begin
        samp_q[ch] <= s_axis_tdata[ch*SampleW +: SampleW];
        vol_q[ch]  <= s_axis_tdata[VolBase + ch*VolumeW +: VolumeW];
      end
      attach_q <= s_axis_tdata[AttachBase +: AttachW];
    end
    if (emit) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

endmodule

@@ rtl/core/fcam_checker.sv @@
module fcam_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fcam_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                           m_axis_tlast
);

  // A result that is not taken stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output result changed while stalled");

  // The input only back-pressures when a result is waiting and not taken.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  // A fresh result after an empty output comes from an earlier accepted item.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 2) && m_axis_tvalid && !$past(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without an accepted item");

  // The configuration port never blocks a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write was refused");

endmodule

bind four_channel_audio_mixer fcam_checker u_fcam_checker (.*);

@@ sim/tb_four_channel_audio_mixer.sv @@
`timescale 1ns / 100ps

module tb_four_channel_audio_mixer;
  import fcam_pkg::*;

  localparam int unsigned RandomItems   = 500;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } mix_result_t;

  typedef enum int unsigned {
    RxOpen,
    RxRandom,
    RxEveryFifth,
    RxQuarter
  } rx_style_e;

  // Keeps its own copy of the registers and the byte counter, works out the
  // mixed sample of each item taken at level 2 or up; checks them in order.
  class mix_scoreboard;
    out_mode_e   mode;
    logic [1:0]  level;
    logic [17:0] buffer_bytes;
    logic [16:0] byte_count;
    mix_result_t pending[$];
    int unsigned checked;
    int unsigned mismatches;
    int unsigned buffer_ends;
    int unsigned per_mode[4];

    function new();
      mode         = ModeLinear16;
      level        = SoundLevelReset;
      buffer_bytes = BufferBytesReset;
      byte_count   = '0;
      checked      = 0;
      mismatches   = 0;
      buffer_ends  = 0;
      foreach (per_mode[m]) per_mode[m] = 0;
    endfunction

    function void write_register(cfg_reg_e idx, logic [17:0] value);
      case (idx)
        RegOutputMode:  mode = out_mode_e'(value[1:0]);
        RegSoundLevel:  level = value[1:0];
        RegBufferBytes: buffer_bytes = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] mulaw_code(int v);
      int unsigned mag;
      int unsigned seg_base;
      int unsigned seg_top;
      logic [7:0]  code;
      bit          found;
      mag      = (v < 0) ? -v : v;
      seg_base = 0;
      code     = MulawClipCode;
      found    = 1'b0;
      if (mag < MulawClip) begin
        // Segment k spans 32 << k values, quantised in steps of 2 << k.
        for (int k = 0; k < 8; k++) begin
          seg_top = seg_base + (16 << (k + 1));
          if (!found && mag < seg_top) begin
            code  = 8'((8'hF0 - 16 * k) | (15 - ((mag - seg_base) >> (k + 1))));
            found = 1'b1;
          end
          seg_base = seg_top;
        end
      end
      if (v < 0) code[7] = 1'b0;
      return code;
    endfunction

    function void note_item(logic [63:0] d);
      logic signed [7:0] smp;
      logic [5:0]        vol;
      int                prod;
      int                sum_full;
      int                sum_small;
      int unsigned       limit;
      int unsigned       next_count;
      mix_result_t       res;
      if (level < SoundLevelMin) return;
      sum_full  = 0;
      sum_small = 0;
      for (int ch = 0; ch < 4; ch++) begin
        if (ch < CHANNELS && !d[56 + ch] && !d[60 + ch]) begin
          smp       = d[8 * ch +: 8];
          vol       = d[32 + 6 * ch +: 6];
          prod      = int'(smp) * int'(vol);
          sum_full  += prod;
          sum_small += prod / 256;
        end
      end
      case (mode)
        ModeLinear16: res.word = sum_full[15:0];
        ModeOffset8:  res.word = {8'h00, 8'(sum_small + 128)};
        ModeMulaw8:   res.word = {8'h00, mulaw_code(sum_full)};
        default:      res.word = {8'h00, 8'(sum_small)};
      endcase
      limit      = (buffer_bytes > MaxBufferBytes) ? MaxBufferBytes : buffer_bytes;
      next_count = byte_count + ((mode == ModeLinear16) ? 2 : 1);
      res.last   = (next_count >= limit);
      byte_count = res.last ? 17'd0 : next_count[16:0];
      if (res.last) buffer_ends++;
      per_mode[mode]++;
      pending.push_back(res);
    endfunction

    function void check_sample(logic [15:0] word, logic last);
      mix_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: word %h last %b", word, last);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.word !== word || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d: expected word %h last %b, got word %h last %b",
                   checked, want.word, want.last, word, last);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  mix_scoreboard sb;
  int unsigned   burst_left = 0;
  int unsigned   gap_max = 3;
  int unsigned   items_sent = 0;
  int unsigned   ignored_items = 0;
  int unsigned   random_items = 0;
  int unsigned   idle_cycles = 0;
  rx_style_e     rx_style = RxOpen;
  int unsigned   rx_count = 0;

  four_channel_audio_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_register(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata, m_axis_tlast);
    end
  end

  // The receiver picks a new stall style whenever its countdown runs out.
  always @(posedge clk_i) begin
    if (rx_count == 0) begin
      rx_style <= rx_style_e'($urandom_range(0, 3));
      rx_count <= $urandom_range(16, 80);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_style)
      RxOpen:       m_axis_tready <= 1'b1;
      RxRandom:     m_axis_tready <= 1'($urandom_range(0, 1));
      RxEveryFifth: m_axis_tready <= (rx_count % 5) != 0;
      default:      m_axis_tready <= (rx_count % 4) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input out_mode_e mode, input logic [1:0] level,
                           input logic [CfgDataW-1:0] bytes, input bit poke_unused);
    write_reg(RegOutputMode, CfgDataW'(mode));
    write_reg(RegSoundLevel, CfgDataW'(level));
    write_reg(RegBufferBytes, bytes);
    if (poke_unused) write_reg(RegUnused, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input logic [InDataW-1:0] d);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops the sender and waits for every outstanding result. The extra
  // cycles cover items still in flight that produce no result.
  task automatic settle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [InDataW-1:0] directed_item(int n);
    case (n)
      0:       return {8'h00, {4{6'd63}}, {4{8'h7F}}};
      1:       return {8'h00, {4{6'd63}}, {4{8'h80}}};
      2:       return {8'h0F, {4{6'd63}}, {4{8'h7F}}};
      3:       return {8'hF0, {4{6'd63}}, {4{8'h80}}};
      // Channel 2 volume-attached, channel 1 period-attached.
      4:       return {8'h24, 6'd33, 6'd63, 6'd63, 6'd1, 8'h7F, 8'h80, 8'h80, 8'h80};
      // A lone product of -1 shows truncation toward zero.
      default: return {8'h0E, 6'd63, 6'd63, 6'd63, 6'd1, 8'h7F, 8'h7F, 8'h7F, 8'hFF};
    endcase
  endfunction

  function automatic logic [InDataW-1:0] random_item();
    logic [3:0][7:0] smp;
    logic [3:0][5:0] vol;
    logic [7:0]      att;
    int unsigned     ch;
    smp = $urandom;
    vol = 24'($urandom);
    att = 8'($urandom);
    ch  = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5: begin
        // Quiet items reach the low mu-law segments.
        for (int i = 0; i < 4; i++) vol[i] = 6'($urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) att = 8'h00;
      end
      6, 7: att = (att | 8'h0F) & ~(8'h11 << ch);
      8: begin
        for (int i = 0; i < 4; i++) begin
          smp[i] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
          if ($urandom_range(0, 1)) vol[i] = 6'd63;
        end
        att = 8'h00;
      end
      default: att = 8'h00;
    endcase
    return {att, vol, smp};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_buffer_bytes();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CfgDataW'(1);
      2:       return CfgDataW'(2);
      3:       return MaxBufferBytes;
      4:       return MaxBufferBytes + CfgDataW'(1);
      5:       return '1;
      6:       return BufferBytesReset;
      7:       return CfgDataW'($urandom_range(2, 131072));
      default: return CfgDataW'($urandom_range(3, 64));
    endcase
  endfunction

  initial begin
    out_mode_e             mode_sel;
    logic [1:0]            level_sel;
    logic [CfgDataW-1:0]   bytes_sel;
    int unsigned           phase_len;
    int unsigned           phase;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int m = 0; m < 4; m++) begin
      case (out_mode_e'(m))
        ModeLinear16: configure(ModeLinear16, 2'd2, '0, 1'b0);
        ModeOffset8:  configure(ModeOffset8, 2'd3, CfgDataW'(1), 1'b0);
        ModeMulaw8:   configure(ModeMulaw8, 2'd2, CfgDataW'(3), 1'b0);
        default:      configure(ModeSigned8, 2'd3, '1, 1'b0);
      endcase
      for (int n = 0; n < 6; n++) send_item(directed_item(n));
      settle();
    end

    phase = 0;
    while (random_items < RandomItems) begin
      mode_sel = out_mode_e'($urandom_range(0, 3));
      if (phase == 1) level_sel = 2'd0;
      else if (phase == 3) level_sel = 2'd1;
      else if ($urandom_range(0, 9) == 0) level_sel = 2'($urandom_range(0, 1));
      else level_sel = 2'($urandom_range(2, 3));
      bytes_sel = pick_buffer_bytes();
      case ($urandom_range(0, 3))
        0:       gap_max = 0;
        1:       gap_max = 3;
        2:       gap_max = 12;
        default: gap_max = 30;
      endcase
      configure(mode_sel, level_sel, bytes_sel, phase == 0);
      phase_len = (level_sel < SoundLevelMin) ? 8 : $urandom_range(20, 60);
      for (int n = 0; n < phase_len; n++) begin
        send_item(random_item());
        if (level_sel < SoundLevelMin) ignored_items++;
        else random_items++;
        if (n == phase_len / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) settle();
      end
      settle();
      phase++;
    end

    $display("Mixed %0d items (%0d at a low sound level) over %0d random settings.",
             items_sent, ignored_items, phase);
    $display("Checked %0d results with %0d buffer ends.", sb.checked, sb.buffer_ends);
    $display("Per mode: linear %0d, offset %0d, mu-law %0d, signed %0d.",
             sb.per_mode[0], sb.per_mode[1], sb.per_mode[2], sb.per_mode[3]);
    if (sb.pending.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending.size());
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
